FILE: hw/rtl/dvfs_pkg.sv
// ----------------------------------------------------------------------------
// dvfs_pkg: shared types and constants of the level-to-fid/vid controller
// Holds the entry layout, controller/datapath handshake structs, command
// codes, control word masks and the fid multiplier table.
// ----------------------------------------------------------------------------
package dvfs_pkg;

   localparam int MAX_STATES_DEF = 16;

   localparam int FREQ_W  = 13;
   localparam int FID_W   = 5;
   localparam int VID_W   = 8;
   localparam int LEVEL_W = 7;
   localparam int CTL_W   = 64;
   localparam int STATE_W = 4;
   localparam int FSB_W   = 8;
   localparam int SETTLE_TIME_W = 16;
   localparam int SETTLE_W = 20;

   localparam int REQ_DATA_W = 88;  // 86 bits of fields, padded to bytes
   localparam int RSP_DATA_W = 72;  // 68 bits of fields, padded to bytes
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_FSB_MHZ     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE_TIME = 1'd1;

   localparam logic [FSB_W-1:0]         FSB_RESET    = 8'd100;
   localparam logic [SETTLE_TIME_W-1:0] SETTLE_RESET = 16'd0;

   localparam logic [SETTLE_W-1:0] SETTLE_MIN = 20'd10000;
   localparam logic [SETTLE_W-1:0] SETTLE_MAX = 20'hFFFFF;
   localparam logic [FID_W-1:0]    FID_LIMIT  = 5'd30;
   localparam logic [LEVEL_W-1:0]  LEVEL_MAX  = 7'd100;

   localparam logic [CTL_W-1:0] BIT_SET_FID = 64'h0000_0000_0001_0000;
   localparam logic [CTL_W-1:0] BIT_SET_VID = 64'h0000_0000_0002_0000;

   // x/10 for x < 81920: (x * 52429) >> 19
   localparam logic [15:0] DIV10_RECIP = 16'd52429;
   localparam int          DIV10_SHIFT = 19;
   // x/100 for x < 2^20: (x * 1342178) >> 27
   localparam logic [20:0] DIV100_RECIP = 21'd1342178;
   localparam int          DIV100_SHIFT = 27;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_LEVEL = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_code_type;

   typedef enum logic [1:0] {
      RD_FIRST,
      RD_LAST,
      RD_CUR,
      RD_SCAN
   } rd_sel_type;

   typedef struct packed {
      logic [FREQ_W-1:0] freq;
      logic [FID_W-1:0]  fid;
      logic [VID_W-1:0]  vid;
   } entry_type;

   typedef struct packed {
      logic       capture;      // take the request beat
      logic       clear;        // empty the table
      logic       ld_mul;       // fsb times multiplier
      logic       ld_div;       // divide by ten
      logic       ld_wr;        // append entry
      rd_sel_type rd_sel;       // table read address source
      logic       cap_lo;
      logic       cap_hi;
      logic       cap_cur;
      logic       lvl_mul;      // span times level, settle count
      logic       lvl_div;      // divide by hundred, form target
      logic       scan_clr;
      logic       scan_adv;
      logic       sel_cap;
      logic       commit;       // switch state, form control word
      logic       beat_second;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       load_ok;
      logic       table_empty;
      logic       hit;
      logic       same_state;
   } dp_status_type;

   // multiplier x10 per fid code; codes 30 and 31 are never used
   function automatic logic [7:0] mult_x10(input logic [FID_W-1:0] fid);
      logic [7:0] m;
      case (fid)
         5'd0:  m = 8'd110;
         5'd1:  m = 8'd115;
         5'd2:  m = 8'd120;
         5'd3:  m = 8'd125;
         5'd4:  m = 8'd50;
         5'd5:  m = 8'd55;
         5'd6:  m = 8'd60;
         5'd7:  m = 8'd65;
         5'd8:  m = 8'd70;
         5'd9:  m = 8'd75;
         5'd10: m = 8'd80;
         5'd11: m = 8'd85;
         5'd12: m = 8'd90;
         5'd13: m = 8'd95;
         5'd14: m = 8'd100;
         5'd15: m = 8'd105;
         5'd16: m = 8'd30;
         5'd17: m = 8'd190;
         5'd18: m = 8'd40;
         5'd19: m = 8'd200;
         5'd20: m = 8'd130;
         5'd21: m = 8'd135;
         5'd22: m = 8'd140;
         5'd23: m = 8'd210;
         5'd24: m = 8'd150;
         5'd25: m = 8'd225;
         5'd26: m = 8'd160;
         5'd27: m = 8'd165;
         5'd28: m = 8'd170;
         5'd29: m = 8'd180;
         default: m = 8'd0;
      endcase
      return m;
   endfunction

endpackage

FILE: hw/rtl/dvfs_ram.sv
// ----------------------------------------------------------------------------
// dvfs_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dvfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/dvfs_dp.sv
// ----------------------------------------------------------------------------
// dvfs_dp: datapath of the level-to-fid/vid controller
// Item and configuration registers, the state table, interpolation
// arithmetic, table scan and result word formation.
// ----------------------------------------------------------------------------
module dvfs_dp
   import dvfs_pkg::*;
#(
   parameter int MAX_STATES = MAX_STATES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int IDX_W = $clog2(MAX_STATES);
   localparam int CNT_W = $clog2(MAX_STATES + 1);

   // item fields
   logic [1:0]         cmd_ff;
   logic [FID_W-1:0]   fid_ff;
   logic [VID_W-1:0]   vid_ff;
   logic [LEVEL_W-1:0] level_ff;
   logic [CTL_W-1:0]   ctl_ff;

   // configuration
   logic [FSB_W-1:0]         fsb_ff;
   logic [SETTLE_TIME_W-1:0] settle_time_ff;

   // table control
   logic [CNT_W-1:0] count_ff;
   logic [IDX_W-1:0] cur_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] sel_ff;

   // arithmetic
   logic [15:0]              ld_prod_ff;
   logic [FREQ_W-1:0]        ld_freq_ff;
   logic [FREQ_W-1:0]        lo_ff;
   logic [FREQ_W-1:0]        hi_ff;
   logic [FREQ_W-1:0]        cur_freq_ff;
   logic signed [21:0]       lvl_prod_ff;
   logic [SETTLE_W-1:0]      settle_ff;
   logic signed [14:0]       target_ff;
   logic [FID_W-1:0]         sel_fid_ff;
   logic [VID_W-1:0]         sel_vid_ff;
   logic                     fid_first_ff;
   logic [CTL_W-1:0]         word_ff;

   entry_type          wr_entry;
   entry_type          rd_entry;
   logic [IDX_W-1:0]   rd_addr;
   logic [CNT_W-1:0]   last_cnt;
   logic [IDX_W-1:0]   last_idx;
   logic [31:0]        div10_full;
   logic [LEVEL_W-1:0] level_sat;
   logic signed [13:0] span;
   logic [21:0]        mag;
   logic [41:0]        div100_full;
   logic [14:0]        quot;
   logic signed [14:0] lo_s;
   logic [22:0]        settle_raw;
   logic [SETTLE_W-1:0] settle_clamp;
   logic               ge_target;
   logic [IDX_W+3:0]   sel_wide;

   assign last_cnt = count_ff - CNT_W'(1);
   assign last_idx = last_cnt[IDX_W-1:0];

   always_comb begin
      case (cmd.rd_sel)
         RD_FIRST: rd_addr = '0;
         RD_LAST:  rd_addr = last_idx;
         RD_CUR:   rd_addr = cur_ff;
         RD_SCAN:  rd_addr = idx_ff;
         default:  rd_addr = idx_ff;
      endcase
   end

   assign wr_entry.freq = ld_freq_ff;
   assign wr_entry.fid  = fid_ff;
   assign wr_entry.vid  = vid_ff;

   dvfs_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MAX_STATES)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.ld_wr),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   // interpolation arithmetic
   assign div10_full  = ld_prod_ff * DIV10_RECIP;
   assign level_sat   = (level_ff > LEVEL_MAX) ? LEVEL_MAX : level_ff;
   assign span        = $signed({1'b0, hi_ff}) - $signed({1'b0, lo_ff});
   assign mag         = lvl_prod_ff[21] ? 22'(-lvl_prod_ff) : 22'(lvl_prod_ff);
   assign div100_full = mag[20:0] * DIV100_RECIP;
   assign quot        = div100_full[41:DIV100_SHIFT];
   assign lo_s        = $signed({2'b00, lo_ff});
   assign settle_raw  = {7'd0, settle_time_ff} * 23'd100;

   always_comb begin
      if (settle_raw < {3'd0, SETTLE_MIN}) begin
         settle_clamp = SETTLE_MIN;
      end else if (settle_raw > {3'd0, SETTLE_MAX}) begin
         settle_clamp = SETTLE_MAX;
      end else begin
         settle_clamp = settle_raw[SETTLE_W-1:0];
      end
   end

   assign ge_target = $signed({2'b00, rd_entry.freq}) >= target_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         fsb_ff         <= FSB_RESET;
         settle_time_ff <= SETTLE_RESET;
         count_ff       <= '0;
         cur_ff         <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FSB_MHZ:     fsb_ff         <= csr_wdata[FSB_W-1:0];
               CSR_SETTLE_TIME: settle_time_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.clear) begin
            count_ff <= '0;
            cur_ff   <= '0;
         end else if (cmd.ld_wr) begin
            count_ff <= count_ff + CNT_W'(1);
            cur_ff   <= count_ff[IDX_W-1:0];
         end else if (cmd.commit) begin
            cur_ff <= sel_ff;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff   <= req_tdata[1:0];
         fid_ff   <= req_tdata[6:2];
         vid_ff   <= req_tdata[14:7];
         level_ff <= req_tdata[21:15];
         ctl_ff   <= req_tdata[85:22];
      end
      if (cmd.ld_mul) begin
         ld_prod_ff <= fsb_ff * mult_x10(fid_ff);
      end
      if (cmd.ld_div) begin
         ld_freq_ff <= div10_full[31:DIV10_SHIFT];
      end
      if (cmd.cap_lo) begin
         lo_ff <= rd_entry.freq;
      end
      if (cmd.cap_hi) begin
         hi_ff <= rd_entry.freq;
      end
      if (cmd.cap_cur) begin
         cur_freq_ff <= rd_entry.freq;
      end
      if (cmd.lvl_mul) begin
         lvl_prod_ff <= span * $signed({1'b0, level_sat});
         settle_ff   <= settle_clamp;
      end
      if (cmd.lvl_div) begin
         target_ff <= lvl_prod_ff[21] ? (lo_s - $signed(quot)) : (lo_s + $signed(quot));
      end
      if (cmd.scan_clr) begin
         idx_ff <= '0;
      end else if (cmd.scan_adv) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
      if (cmd.sel_cap) begin
         sel_ff     <= idx_ff;
         sel_fid_ff <= rd_entry.fid;
         sel_vid_ff <= rd_entry.vid;
      end
      if (cmd.commit) begin
         fid_first_ff <= $signed({2'b00, cur_freq_ff}) > target_ff;
         word_ff      <= {ctl_ff[63:52], settle_ff, ctl_ff[31:16], sel_vid_ff,
                          3'd0, sel_fid_ff};
      end
   end

   assign status.cmd         = cmd_ff;
   assign status.load_ok     = (fid_ff != '0) && (vid_ff != '0) && (fid_ff < FID_LIMIT)
                               && (count_ff != CNT_W'(MAX_STATES));
   assign status.table_empty = (count_ff == '0);
   assign status.hit         = ge_target || (idx_ff == last_idx);
   assign status.same_state  = (sel_ff == cur_ff);

   assign sel_wide  = {4'd0, sel_ff};
   assign rsp_tlast = cmd.beat_second;
   assign rsp_tdata = {4'd0, sel_wide[STATE_W-1:0],
                       word_ff | ((fid_first_ff ^ cmd.beat_second) ? BIT_SET_FID
                                                                   : BIT_SET_VID)};

endmodule

FILE: hw/rtl/dvfs_ctrl.sv
// ----------------------------------------------------------------------------
// dvfs_ctrl: sequencer of the level-to-fid/vid controller
// Steps the datapath through entry loads, target interpolation, the table
// scan and the two result beats.
// ----------------------------------------------------------------------------
module dvfs_ctrl
   import dvfs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_LD_MUL,
      S_LD_DIV,
      S_LD_WR,
      S_RD_FIRST,
      S_RD_LAST,
      S_RD_CUR,
      S_LVL_MUL,
      S_LVL_DIV,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_CHECK,
      S_EMIT0,
      S_EMIT1
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.rd_sel = RD_SCAN;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (status.cmd)
               CMD_LOAD:  state_in = status.load_ok ? S_LD_MUL : S_IDLE;
               CMD_LEVEL: state_in = status.table_empty ? S_IDLE : S_RD_FIRST;
               CMD_CLEAR: begin
                  cmd.clear = 1'b1;
                  state_in  = S_IDLE;
               end
               default:   state_in = S_IDLE;
            endcase
         end
         S_LD_MUL: begin
            cmd.ld_mul = 1'b1;
            state_in   = S_LD_DIV;
         end
         S_LD_DIV: begin
            cmd.ld_div = 1'b1;
            state_in   = S_LD_WR;
         end
         S_LD_WR: begin
            cmd.ld_wr = 1'b1;
            state_in  = S_IDLE;
         end
         S_RD_FIRST: begin
            cmd.rd_sel = RD_FIRST;
            state_in   = S_RD_LAST;
         end
         S_RD_LAST: begin
            cmd.rd_sel = RD_LAST;
            cmd.cap_lo = 1'b1;
            state_in   = S_RD_CUR;
         end
         S_RD_CUR: begin
            cmd.rd_sel = RD_CUR;
            cmd.cap_hi = 1'b1;
            state_in   = S_LVL_MUL;
         end
         S_LVL_MUL: begin
            cmd.cap_cur = 1'b1;
            cmd.lvl_mul = 1'b1;
            state_in    = S_LVL_DIV;
         end
         S_LVL_DIV: begin
            cmd.lvl_div  = 1'b1;
            cmd.scan_clr = 1'b1;
            state_in     = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (status.hit) begin
               cmd.sel_cap = 1'b1;
               state_in    = S_CHECK;
            end else begin
               cmd.scan_adv = 1'b1;
               state_in     = S_SCAN_RD;
            end
         end
         S_CHECK: begin
            if (status.same_state) begin
               state_in = S_IDLE;
            end else begin
               cmd.commit = 1'b1;
               state_in   = S_EMIT0;
            end
         end
         S_EMIT0: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = S_EMIT1;
            end
         end
         S_EMIT1: begin
            rsp_tvalid      = 1'b1;
            cmd.beat_second = 1'b1;
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

FILE: hw/rtl/dvfs_level_to_fid_vid.sv
// ----------------------------------------------------------------------------
// dvfs_level_to_fid_vid: performance level to fid/vid control word writer
// Sequence: a load is checked, scaled and appended to the table; a level
//   request reads the first, last and current entries, interpolates the target
//   and scans the entries (at most the table fill), a RAM read then a compare
//   per entry. Throughput: one item at a time; the next beat is taken once all
//   beats of the previous item are delivered. A clear is done at decode.
// Reset: synchronous, active high; the table is emptied, fsb_mhz returns to
//   100 and settle_time to 0. Table contents are not cleared.
// ----------------------------------------------------------------------------
module dvfs_level_to_fid_vid
   import dvfs_pkg::*;
#(
   parameter int MAX_STATES = MAX_STATES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [1:0] cmd, [6:2] fid_code, [14:7] vid_code, [21:15] level,
   // [85:22] ctl_in, [87:86] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [63:0] ctl_word, [67:64] new_state, [71:68] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   // register writes: index 0 fsb_mhz, index 1 settle_time
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // register writes are always taken and land at once; send them only while
   // no item is in flight
   assign csr_ready = 1'b1;

   // sequencer: owns both handshakes and steps the datapath
   dvfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (dp_status),
      .cmd        (dp_cmd)
   );

   // datapath: table RAM, arithmetic and result word; the result beat is
   // held in registers until taken
   dvfs_dp #(
      .MAX_STATES (MAX_STATES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .csr_we    (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (dp_cmd),
      .status    (dp_status),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule
